FILE: hw/rtl/bdq_pkg.sv
// Shared opcode, status and sizing constants for the bounded deque with search.
package bdq_pkg;

    localparam int DATA_W       = 32;
    localparam int OP_W         = 3;
    localparam int STATUS_W     = 2;
    localparam int DEF_CAPACITY = 16;

    typedef logic [OP_W-1:0]     opcode_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam opcode_t OP_PUSH_FRONT = 3'd0;
    localparam opcode_t OP_PUSH_BACK  = 3'd1;
    localparam opcode_t OP_POP_FRONT  = 3'd2;
    localparam opcode_t OP_SEARCH     = 3'd3;
    localparam opcode_t OP_CLEAR      = 3'd4;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

endpackage

FILE: hw/rtl/bdq_ring_mem.sv
// Entry storage for the deque ring: one write port, one registered read port.
module bdq_ring_mem #(
    parameter int DEPTH  = bdq_pkg::DEF_CAPACITY,
    parameter int DATA_W = bdq_pkg::DATA_W
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);
    import bdq_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/bounded_deque_with_search_top.sv
// Top level of the bounded deque with search: sequencer, pointers and compare unit.
//
//  channel   | handshake                      | payload
//  ----------+--------------------------------+------------------------------------------
//  request   | start in, busy out             | opcode, item_value
//  result    | done out (one-cycle strobe)    | popped_value, found, status, entry_count
//
// Push, clear, unused opcodes, an empty pop and an empty search answer in the
// cycle after the request is taken and leave busy low. A pop reads the front
// entry through the registered memory port and answers from the pop state.
// A search runs one stored entry per cycle through the single comparator,
// front to back, and stops on the first hit or after the last live entry.
// busy stays high while a pop or search is in flight.
// Reset (rst_n low, asynchronous) empties the deque; entry contents are not
// cleared since only written entries are ever read.
// The receiver cannot stall: done is high for exactly one cycle per request.
module bounded_deque_with_search_top #(
    parameter int CAPACITY = bdq_pkg::DEF_CAPACITY
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  bdq_pkg::opcode_t                  opcode,
    input  logic signed [bdq_pkg::DATA_W-1:0] item_value,
    output logic                              done,
    output logic signed [bdq_pkg::DATA_W-1:0] popped_value,
    output logic                              found,
    output bdq_pkg::status_t                  status,
    output logic [$clog2(CAPACITY+1)-1:0]     entry_count
);
    import bdq_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = IDX_W + 1;
    localparam int LAST  = CAPACITY - 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_SRCH = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [IDX_W-1:0]  front_reg, front_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  checked_reg, checked_next;
    logic [DATA_W-1:0] key_reg, key_next;

    logic              done_reg, done_next;
    logic [DATA_W-1:0] popped_reg, popped_next;
    logic              found_reg, found_next;
    status_t           status_reg, status_next;
    logic [CNT_W-1:0]  cnt_out_reg, cnt_out_next;

    logic              accept;
    logic              is_full;
    logic              is_empty;
    logic              mem_wr_en;
    logic [IDX_W-1:0]  mem_wr_addr;
    logic [IDX_W-1:0]  mem_rd_addr;
    logic [DATA_W-1:0] mem_rd_data;
    logic [IDX_W-1:0]  front_dec;
    logic [IDX_W-1:0]  front_inc;
    logic [IDX_W-1:0]  rd_ptr_inc;
    logic [SUM_W-1:0]  back_sum;
    logic [IDX_W-1:0]  back_idx;
    logic              hit;
    logic              last_entry;

    assign accept   = start && (state_reg == S_IDLE);
    assign busy     = (state_reg != S_IDLE);
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    // ring pointer arithmetic, wrap without division
    assign front_dec  = (front_reg == '0) ? IDX_W'(LAST) : front_reg - 1'b1;
    assign front_inc  = (front_reg == IDX_W'(LAST)) ? '0 : front_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == IDX_W'(LAST)) ? '0 : rd_ptr_reg + 1'b1;
    assign back_sum   = SUM_W'(front_reg) + SUM_W'(count_reg);
    assign back_idx   = (back_sum >= SUM_W'(CAPACITY))
                      ? IDX_W'(back_sum - SUM_W'(CAPACITY)) : IDX_W'(back_sum);

    assign mem_wr_en   = accept && !is_full
                      && (opcode == OP_PUSH_FRONT || opcode == OP_PUSH_BACK);
    assign mem_wr_addr = (opcode == OP_PUSH_FRONT) ? front_dec : back_idx;
    // idle: front entry (pop or first search read); searching: next entry
    assign mem_rd_addr = (state_reg == S_IDLE) ? front_reg : rd_ptr_reg;

    // shared compare unit
    assign hit        = (mem_rd_data == key_reg);
    assign last_entry = (CNT_W'(checked_reg + 1'b1) == count_reg);

    bdq_ring_mem #(
        .DEPTH  (CAPACITY),
        .DATA_W (DATA_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (item_value),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    always_comb
    begin
        state_next   = state_reg;
        front_next   = front_reg;
        count_next   = count_reg;
        rd_ptr_next  = rd_ptr_reg;
        checked_next = checked_reg;
        key_next     = key_reg;
        done_next    = 1'b0;
        popped_next  = popped_reg;
        found_next   = found_reg;
        status_next  = status_reg;
        cnt_out_next = cnt_out_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    popped_next  = '0;
                    found_next   = 1'b0;
                    status_next  = ST_OK;
                    cnt_out_next = count_reg;
                    key_next     = item_value;
                    unique case (opcode)
                        OP_PUSH_FRONT:
                        begin
                            done_next = 1'b1;
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                front_next   = front_dec;
                                count_next   = count_reg + 1'b1;
                                cnt_out_next = count_reg + 1'b1;
                            end
                        end
                        OP_PUSH_BACK:
                        begin
                            done_next = 1'b1;
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                count_next   = count_reg + 1'b1;
                                cnt_out_next = count_reg + 1'b1;
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_POP;
                            end
                        end
                        OP_SEARCH:
                        begin
                            if (is_empty)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next   = S_SRCH;
                                rd_ptr_next  = front_inc;
                                checked_next = '0;
                            end
                        end
                        OP_CLEAR:
                        begin
                            done_next    = 1'b1;
                            front_next   = '0;
                            count_next   = '0;
                            cnt_out_next = '0;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                done_next    = 1'b1;
                popped_next  = mem_rd_data;
                front_next   = front_inc;
                count_next   = count_reg - 1'b1;
                cnt_out_next = count_reg - 1'b1;
                state_next   = S_IDLE;
            end
            S_SRCH:
            begin
                if (hit || last_entry)
                begin
                    done_next  = 1'b1;
                    found_next = hit;
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_ptr_next  = rd_ptr_inc;
                    checked_next = checked_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            front_reg   <= '0;
            count_reg   <= '0;
            rd_ptr_reg  <= '0;
            checked_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            count_reg   <= count_next;
            rd_ptr_reg  <= rd_ptr_next;
            checked_reg <= checked_next;
            done_reg    <= done_next;
        end
    end

    // payload registers, qualified by done_reg
    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        popped_reg  <= popped_next;
        found_reg   <= found_next;
        status_reg  <= status_next;
        cnt_out_reg <= cnt_out_next;
    end

    assign done         = done_reg;
    assign popped_value = popped_reg;
    assign found        = found_reg;
    assign status       = status_reg;
    assign entry_count  = cnt_out_reg;

    // the result strobe only fires once the sequencer is back at idle
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    // a full status is only reported with a full deque
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> (entry_count == CNT_W'(CAPACITY)))
        else $error("full status with room left");

    // held count never exceeds capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("held count above capacity");

    // a search of a non-empty deque always occupies the compare unit
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && opcode == OP_SEARCH && !is_empty) |=> (busy && !done))
        else $error("search skipped the compare sequence");

endmodule

FILE: sim/bounded_deque_with_search_top_test.sv
// Self-checking testbench for the bounded deque with search: directed and random requests.
module bounded_deque_with_search_top_test;
    import bdq_pkg::*;

    localparam int CAP             = DEF_CAPACITY;
    localparam int CNT_W           = $clog2(CAP + 1);
    localparam int TARGET_REQUESTS = 650;
    localparam int MAX_IDLE        = 16;
    // tail after the last result, with plenty of slack for stray strobes
    localparam int TAIL_CYCLES     = 2 * CAP + 8;
    // bound on the whole run, several times the slowest expected run length
    localparam int CYCLE_LIMIT     = 200000;
    localparam int REPORT_MAX      = 10;

    // opcodes the block must ignore
    localparam opcode_t OP_RSVD_FIRST = 3'd5;
    localparam opcode_t OP_RSVD_LAST  = 3'd7;

    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    typedef struct {
        opcode_t                  op;
        logic signed [DATA_W-1:0] val;
    } deque_request_t;

    typedef struct {
        logic signed [DATA_W-1:0] popped;
        logic                     hit;
        status_t                  st;
        logic [CNT_W-1:0]         count;
    } deque_result_t;

    // ------------------------------------------------------------------
    // DUT connections; every input starts at a known value
    // ------------------------------------------------------------------
    logic                     clk        = 1'b0;
    logic                     rst_n      = 1'b0;
    logic                     start      = 1'b0;
    opcode_t                  opcode     = OP_PUSH_FRONT;
    logic signed [DATA_W-1:0] item_value = '0;
    logic                     busy;
    logic                     done;
    logic signed [DATA_W-1:0] popped_value;
    logic                     found;
    status_t                  status;
    logic [CNT_W-1:0]         entry_count;

    bounded_deque_with_search_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .item_value   (item_value),
        .done         (done),
        .popped_value (popped_value),
        .found        (found),
        .status       (status),
        .entry_count  (entry_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the deque: ring of entries, front index and fill level
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] shadow_entries [CAP];
    int                       shadow_front = 0;
    int                       shadow_count = 0;

    deque_request_t pending_requests [$];
    deque_result_t  expected_results [$];

    logic           req_taken     = 1'b0;
    int             idle_left     = 0;
    int             quiet_left    = 0;
    int             cycle_count   = 0;
    int             mismatch_count = 0;
    deque_request_t next_req;
    deque_result_t  want;

    // Applies one request to the shadow deque and returns the answer it must give.
    function automatic deque_result_t apply_deque_op(opcode_t op, logic signed [DATA_W-1:0] val);
        deque_result_t r;
        r.popped = '0;
        r.hit    = 1'b0;
        r.st     = ST_OK;
        case (op)
            OP_PUSH_FRONT:
                if (shadow_count >= CAP)
                    r.st = ST_FULL;
                else
                begin
                    shadow_front = (shadow_front + CAP - 1) % CAP;
                    shadow_entries[shadow_front] = val;
                    shadow_count++;
                end
            OP_PUSH_BACK:
                if (shadow_count >= CAP)
                    r.st = ST_FULL;
                else
                begin
                    shadow_entries[(shadow_front + shadow_count) % CAP] = val;
                    shadow_count++;
                end
            OP_POP_FRONT:
                if (shadow_count == 0)
                    r.st = ST_EMPTY;
                else
                begin
                    r.popped     = shadow_entries[shadow_front];
                    shadow_front = (shadow_front + 1) % CAP;
                    shadow_count--;
                end
            OP_SEARCH:
                // only live entries are compared, front to back
                for (int k = 0; k < shadow_count; k++)
                    if (shadow_entries[(shadow_front + k) % CAP] == val)
                        r.hit = 1'b1;
            OP_CLEAR:
            begin
                shadow_front = 0;
                shadow_count = 0;
            end
            default: ;  // reserved opcodes change nothing
        endcase
        r.count = shadow_count[CNT_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: checks result strobes, records accepted requests, watchdog.
    // A result is checked before a request taken on the same edge is logged,
    // so a strobe can never be matched against its own request.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("CHECK FAILED");
            $finish;
        end

        if (rst_n && done !== 1'b0)
        begin
            if (expected_results.size() == 0)
            begin
                if (mismatch_count < REPORT_MAX)
                    $display("cycle %0d: result strobe with no request outstanding", cycle_count);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (popped_value !== want.popped || found !== want.hit ||
                    status !== want.st || entry_count !== want.count)
                begin
                    if (mismatch_count < REPORT_MAX)
                    begin
                        $write("cycle %0d: expected popped=%h found=%b status=%0d count=%0d,",
                               cycle_count, want.popped, want.hit, want.st, want.count);
                        $display(" got popped=%h found=%b status=%0d count=%0d",
                                 popped_value, found, status, entry_count);
                    end
                    mismatch_count++;
                end
            end
        end

        req_taken = rst_n && start && !busy;
        if (req_taken)
            expected_results.push_back(apply_deque_op(opcode, item_value));
    end

    // ------------------------------------------------------------------
    // Driver: presents queued requests on the falling edge. After each
    // request it inserts a random idle gap, with occasional quiet runs
    // where requests go back to back.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!start || req_taken))
        begin
            if (idle_left > 0)
            begin
                idle_left <= idle_left - 1;
                start     <= 1'b0;
            end
            else if (pending_requests.size() > 0)
            begin
                next_req    = pending_requests.pop_front();
                opcode     <= next_req.op;
                item_value <= next_req.val;
                start      <= 1'b1;
                if (quiet_left > 0)
                begin
                    quiet_left--;
                    idle_left <= 0;
                end
                else
                begin
                    idle_left <= $urandom_range(0, MAX_IDLE);
                    if ($urandom_range(0, 19) == 0)
                        quiet_left = $urandom_range(10, 40);
                end
            end
            else
                start <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus generation. plan_count tracks the expected fill level so the
    // random episodes can steer the deque to full and to empty.
    // ------------------------------------------------------------------
    int                       plan_count = 0;
    logic signed [DATA_W-1:0] value_pool [8];

    task automatic queue_request(opcode_t op, logic signed [DATA_W-1:0] val);
        deque_request_t req;
        req.op  = op;
        req.val = val;
        pending_requests.push_back(req);
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: if (plan_count < CAP) plan_count++;
            OP_POP_FRONT:                if (plan_count > 0) plan_count--;
            OP_CLEAR:                    plan_count = 0;
            default: ;
        endcase
    endtask

    // Mostly values from a small pool so searches hit; sometimes fully random.
    function automatic logic signed [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 4) == 0)
            return $urandom;
        return value_pool[$urandom_range(0, 7)];
    endfunction

    function automatic opcode_t pick_push();
        return ($urandom_range(0, 1) == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    endfunction

    initial
    begin
        int episode;
        int kind;
        int roll;

        // directed part: empty cases, extreme values, hits and misses, reserved opcodes
        queue_request(OP_POP_FRONT, $urandom);     // pop on empty
        queue_request(OP_SEARCH, '0);              // search on empty
        queue_request(OP_PUSH_FRONT, VAL_MIN);
        queue_request(OP_PUSH_BACK, VAL_MAX);
        queue_request(OP_PUSH_FRONT, '0);
        queue_request(OP_PUSH_BACK, -1);
        queue_request(OP_SEARCH, VAL_MIN);
        queue_request(OP_SEARCH, VAL_MAX);
        queue_request(OP_SEARCH, -1);              // hit on the last entry
        queue_request(OP_SEARCH, 32'sd12345);      // miss on a non-empty list
        for (int op = OP_RSVD_FIRST; op <= OP_RSVD_LAST; op++)
            queue_request(opcode_t'(op), $urandom);
        queue_request(OP_POP_FRONT, $urandom);
        queue_request(OP_POP_FRONT, $urandom);
        queue_request(OP_CLEAR, $urandom);
        queue_request(OP_SEARCH, -1);              // stale entry must not match after clear
        queue_request(OP_POP_FRONT, $urandom);     // pop on empty after clear

        // random part: fill, drain and mixed episodes
        episode = 0;
        while (pending_requests.size() < TARGET_REQUESTS)
        begin
            foreach (value_pool[i])
                case ($urandom_range(0, 11))
                    0:       value_pool[i] = VAL_MIN;
                    1:       value_pool[i] = VAL_MAX;
                    2:       value_pool[i] = '0;
                    3:       value_pool[i] = -1;
                    default: value_pool[i] = $urandom;
                endcase

            kind = (episode == 0) ? 0 : $urandom_range(0, 3);
            case (kind)
                0:
                begin
                    // fill to capacity, push into a full list, then search it
                    while (plan_count < CAP)
                        queue_request(pick_push(), pick_value());
                    repeat ($urandom_range(1, 3))
                        queue_request(pick_push(), pick_value());
                    repeat ($urandom_range(2, 6))
                        queue_request(OP_SEARCH, pick_value());
                end
                1:
                begin
                    // drain to empty with searches in between, then pop past empty
                    while (plan_count > 0)
                    begin
                        queue_request(OP_POP_FRONT, $urandom);
                        if ($urandom_range(0, 3) == 0)
                            queue_request(OP_SEARCH, pick_value());
                    end
                    repeat ($urandom_range(1, 2))
                        queue_request(OP_POP_FRONT, $urandom);
                end
                default:
                begin
                    repeat ($urandom_range(10, 30))
                    begin
                        roll = $urandom_range(0, 99);
                        if (roll < 40)
                            queue_request(pick_push(), pick_value());
                        else if (roll < 65)
                            queue_request(OP_POP_FRONT, $urandom);
                        else if (roll < 90)
                            queue_request(OP_SEARCH, pick_value());
                        else if (roll < 93)
                            queue_request(OP_CLEAR, $urandom);
                        else
                            queue_request(opcode_t'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST)),
                                          $urandom);
                    end
                end
            endcase
            episode++;
        end

        // reset: asserted from time zero, released on a falling edge
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // run until every request is in and every result has come back
        while (pending_requests.size() != 0 || start || expected_results.size() != 0)
            @(posedge clk);
        // catch any stray strobe after the last result
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
